// ----- rtl/u8n1_pkg.sv -----
// ----------------------------------------------------------------------------
// u8n1_pkg: shared definitions for the 8N1 UART transceiver
// Field widths, frame constants, line phase codes and the status structs that
// pass between the receiver, the transmitter and the top level.
// ----------------------------------------------------------------------------
package u8n1_pkg;

  localparam int BYTE_W    = 8;
  localparam int BIT_SEL_W = $clog2(BYTE_W);
  localparam int CNT_W     = 16;
  localparam int IDX_W     = 4;
  localparam int DATA_BITS = 8;

  localparam logic [IDX_W-1:0] DATA_BITS_IDX = IDX_W'(DATA_BITS);
  localparam logic [IDX_W-1:0] BYTE_BITS_IDX = IDX_W'(BYTE_W);
  localparam logic [CNT_W-1:0] BIT_PERIOD_RESET = CNT_W'(3333);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_status_t;

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } result_t;

endpackage

// ----- rtl/u8n1_channels.sv -----
// ----------------------------------------------------------------------------
// u8n1 channels: valid/ready interfaces for the transceiver
// One interface carries line ticks in, the other carries per-tick results out.
// ----------------------------------------------------------------------------
interface u8n1_in_if;
  logic                       valid;
  logic                       ready;
  logic                       rx_line;
  logic                       tx_start;
  logic [u8n1_pkg::BYTE_W-1:0] tx_byte;

  modport source (output valid, rx_line, tx_start, tx_byte, input ready);
  modport sink   (input valid, rx_line, tx_start, tx_byte, output ready);
endinterface

interface u8n1_out_if;
  logic                       valid;
  logic                       ready;
  logic                       tx_line;
  logic                       tx_busy;
  logic                       rx_valid;
  logic [u8n1_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, tx_line, tx_busy, rx_valid, rx_byte, input ready);
  modport sink   (input valid, tx_line, tx_busy, rx_valid, rx_byte, output ready);
endinterface

// ----- rtl/uart_8n1_transceiver_core.sv -----
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_core: 8N1 UART transmitter and receiver
// Each transfer on the input channel is one tick of the serial line; each
// transfer on the output channel is the matching line and status result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one line tick per transfer: the receive line level, a send
//   request and the byte to send. out_ch returns exactly one result per
//   tick: transmit line level, transmitter busy, a one-tick received-byte
//   strobe and the receive shift register.
//   The bit period in ticks is written through cfg_we / cfg_wdata while no
//   tick is in flight; a value of zero is treated as one.
//   A tick's result is registered in the result register, or in the skid
//   register while out_ch stalls. Throughput is one tick per cycle while
//   out_ch does not stall, set by the single-pass update of the receiver
//   and transmitter counters between the input transfer and the result register.
//   A two-entry output buffer (result register plus skid register) lets a
//   tick be taken while a result still waits; in_ch.ready is a register, so
//   when out_ch stalls, at most one more tick is taken and then ready drops
//   until the output drains. Line state only moves on accepted ticks.
//   Synchronous reset returns both line engines to idle, empties the output
//   buffer and loads the bit period with 3333 ticks.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_core (
  input  logic                         clk,
  input  logic                         rst,
  u8n1_in_if.sink                      in_ch,
  u8n1_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [u8n1_pkg::CNT_W-1:0]   cfg_wdata
);

  logic [u8n1_pkg::CNT_W-1:0] bit_period_ticks;
  logic [u8n1_pkg::CNT_W-1:0] period;

  logic                 in_fire;
  logic                 out_fire;
  u8n1_pkg::tx_status_t tx_status;
  u8n1_pkg::rx_status_t rx_status;
  u8n1_pkg::result_t    result;

  // Output buffer: main is what out_ch shows, skid catches one extra result.
  u8n1_pkg::result_t    main_data;
  logic                 main_valid;
  u8n1_pkg::result_t    skid_data;
  logic                 skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks <= u8n1_pkg::BIT_PERIOD_RESET;
    end else if (cfg_we) begin
      bit_period_ticks <= cfg_wdata;
    end
  end

  // A zero period runs as a one-tick period.
  assign period = (bit_period_ticks == '0) ? u8n1_pkg::CNT_W'(1) : bit_period_ticks;

  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && !skid_valid;
  assign out_fire    = main_valid && out_ch.ready;

  u8n1_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .period  (period),
    .rx_line (in_ch.rx_line),
    .status  (rx_status)
  );

  u8n1_tx u_tx (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_fire),
    .period   (period),
    .tx_start (in_ch.tx_start),
    .tx_byte  (in_ch.tx_byte),
    .status   (tx_status)
  );

  assign result.tx_line  = tx_status.line;
  assign result.tx_busy  = tx_status.busy;
  assign result.rx_valid = rx_status.valid;
  assign result.rx_byte  = rx_status.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= in_fire;
        end
      end else if (in_fire) begin
        if (!main_valid) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers follow the same steering as the valid flags.
  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (in_fire) begin
        main_data <= result;
      end
    end else if (in_fire) begin
      if (!main_valid) begin
        main_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  assign out_ch.valid    = main_valid;
  assign out_ch.tx_line  = main_data.tx_line;
  assign out_ch.tx_busy  = main_data.tx_busy;
  assign out_ch.rx_valid = main_data.rx_valid;
  assign out_ch.rx_byte  = main_data.rx_byte;

  // The skid register is only filled behind an occupied result register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid register holds a result while the output is empty");

  // A tick taken while the output is full and stalled must land in the skid.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (in_fire && main_valid && !out_fire) |=> skid_valid)
    else $error("result lost on a stalled output");

  // Draining the output with a skid entry pending keeps the output occupied.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (out_fire && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved to the output register");

endmodule

// ----- rtl/u8n1_rx.sv -----
// ----------------------------------------------------------------------------
// u8n1_rx: serial receiver
// Waits for a low start bit, moves to mid-bit, samples each data bit once per
// bit period and reports the byte at mid stop bit.
// ----------------------------------------------------------------------------
module u8n1_rx (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [u8n1_pkg::CNT_W-1:0]    period,
  input  logic                          rx_line,
  output u8n1_pkg::rx_status_t          status
);

  u8n1_pkg::phase_t                  rx_phase;
  u8n1_pkg::phase_t                  rx_phase_next;
  logic [u8n1_pkg::CNT_W-1:0]        rx_tick_count;
  logic [u8n1_pkg::CNT_W-1:0]        rx_tick_count_next;
  logic [u8n1_pkg::IDX_W-1:0]        rx_bit_index;
  logic [u8n1_pkg::IDX_W-1:0]        rx_bit_index_next;
  logic [u8n1_pkg::BYTE_W-1:0]       rx_shift;
  logic [u8n1_pkg::BYTE_W-1:0]       rx_shift_next;
  logic [u8n1_pkg::CNT_W-1:0]        count_inc;
  logic                              done;

  assign count_inc = rx_tick_count + u8n1_pkg::CNT_W'(1);

  always_comb begin
    rx_phase_next      = rx_phase;
    rx_tick_count_next = rx_tick_count;
    rx_bit_index_next  = rx_bit_index;
    rx_shift_next      = rx_shift;
    done               = 1'b0;
    unique case (rx_phase)
      u8n1_pkg::PH_IDLE: begin
        if (!rx_line) begin
          rx_phase_next      = u8n1_pkg::PH_START;
          rx_tick_count_next = '0;
          rx_bit_index_next  = '0;
          rx_shift_next      = '0;
        end
      end
      u8n1_pkg::PH_START: begin
        rx_tick_count_next = count_inc;
        // Half a bit period lands the sampling point at mid-bit.
        if (count_inc >= (period >> 1)) begin
          rx_phase_next      = u8n1_pkg::PH_DATA;
          rx_tick_count_next = '0;
          rx_bit_index_next  = '0;
        end
      end
      u8n1_pkg::PH_DATA: begin
        rx_tick_count_next = count_inc;
        if (count_inc >= period) begin
          rx_tick_count_next = '0;
          // Bits beyond the byte width are sampled but dropped.
          if (rx_bit_index < u8n1_pkg::BYTE_BITS_IDX) begin
            rx_shift_next[rx_bit_index[u8n1_pkg::BIT_SEL_W-1:0]] = rx_line;
          end
          rx_bit_index_next = rx_bit_index + u8n1_pkg::IDX_W'(1);
          if (rx_bit_index_next >= u8n1_pkg::DATA_BITS_IDX) begin
            rx_phase_next = u8n1_pkg::PH_STOP;
          end
        end
      end
      u8n1_pkg::PH_STOP: begin
        rx_tick_count_next = count_inc;
        if (count_inc >= period) begin
          rx_tick_count_next = '0;
          rx_phase_next      = u8n1_pkg::PH_IDLE;
          done               = 1'b1;
        end
      end
      default: begin
        rx_phase_next = u8n1_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= u8n1_pkg::PH_IDLE;
      rx_tick_count <= '0;
      rx_bit_index  <= '0;
      rx_shift      <= '0;
    end else if (advance) begin
      rx_phase      <= rx_phase_next;
      rx_tick_count <= rx_tick_count_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_shift      <= rx_shift_next;
    end
  end

  assign status.valid = done;
  assign status.data  = rx_shift_next;

  // The bit index never reaches the number of data bits while data bits are sampled.
  a_rx_index_bound: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == u8n1_pkg::PH_DATA) |-> (rx_bit_index < u8n1_pkg::DATA_BITS_IDX))
    else $error("rx bit index out of range in data phase");

endmodule

// ----- rtl/u8n1_tx.sv -----
// ----------------------------------------------------------------------------
// u8n1_tx: serial transmitter
// Sends a low start bit, the data bits LSB first and a high stop bit, each
// lasting one bit period.
// ----------------------------------------------------------------------------
module u8n1_tx (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [u8n1_pkg::CNT_W-1:0]    period,
  input  logic                          tx_start,
  input  logic [u8n1_pkg::BYTE_W-1:0]   tx_byte,
  output u8n1_pkg::tx_status_t          status
);

  u8n1_pkg::phase_t                  tx_phase;
  u8n1_pkg::phase_t                  tx_phase_next;
  logic [u8n1_pkg::CNT_W-1:0]        tx_tick_count;
  logic [u8n1_pkg::CNT_W-1:0]        tx_tick_count_next;
  logic [u8n1_pkg::IDX_W-1:0]        tx_bit_index;
  logic [u8n1_pkg::IDX_W-1:0]        tx_bit_index_next;
  logic [u8n1_pkg::BYTE_W-1:0]       tx_shift;
  logic [u8n1_pkg::BYTE_W-1:0]       tx_shift_next;
  logic [u8n1_pkg::CNT_W-1:0]        count_inc;
  logic                              level;

  assign count_inc = tx_tick_count + u8n1_pkg::CNT_W'(1);

  always_comb begin
    tx_phase_next      = tx_phase;
    tx_tick_count_next = tx_tick_count;
    tx_bit_index_next  = tx_bit_index;
    tx_shift_next      = tx_shift;
    if (tx_phase != u8n1_pkg::PH_IDLE) begin
      tx_tick_count_next = count_inc;
      if (count_inc >= period) begin
        tx_tick_count_next = '0;
        unique case (tx_phase)
          u8n1_pkg::PH_START: begin
            tx_phase_next     = u8n1_pkg::PH_DATA;
            tx_bit_index_next = '0;
          end
          u8n1_pkg::PH_DATA: begin
            tx_bit_index_next = tx_bit_index + u8n1_pkg::IDX_W'(1);
            if (tx_bit_index_next >= u8n1_pkg::DATA_BITS_IDX) begin
              tx_phase_next = u8n1_pkg::PH_STOP;
            end
          end
          default: begin
            tx_phase_next = u8n1_pkg::PH_IDLE;
          end
        endcase
      end
    end
    // A start is taken on the same tick on which the previous stop bit ends.
    if (tx_phase_next == u8n1_pkg::PH_IDLE && tx_start) begin
      tx_shift_next      = tx_byte;
      tx_phase_next      = u8n1_pkg::PH_START;
      tx_tick_count_next = '0;
      tx_bit_index_next  = '0;
    end
  end

  always_comb begin
    unique case (tx_phase_next)
      u8n1_pkg::PH_START: level = 1'b0;
      u8n1_pkg::PH_DATA: begin
        if (tx_bit_index_next < u8n1_pkg::BYTE_BITS_IDX) begin
          level = tx_shift_next[tx_bit_index_next[u8n1_pkg::BIT_SEL_W-1:0]];
        end else begin
          level = 1'b0;
        end
      end
      default: level = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase      <= u8n1_pkg::PH_IDLE;
      tx_tick_count <= '0;
      tx_bit_index  <= '0;
      tx_shift      <= '0;
    end else if (advance) begin
      tx_phase      <= tx_phase_next;
      tx_tick_count <= tx_tick_count_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_shift      <= tx_shift_next;
    end
  end

  assign status.line = level;
  assign status.busy = (tx_phase_next != u8n1_pkg::PH_IDLE);

  // An idle transmitter always has its bit timer cleared.
  a_tx_idle_count: assert property (@(posedge clk) disable iff (rst)
    (tx_phase == u8n1_pkg::PH_IDLE) |-> (tx_tick_count == '0))
    else $error("tx bit timer not cleared while idle");

endmodule

// ----- test/tb_uart_8n1_transceiver_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_8n1_transceiver_core: self-checking bench for the 8N1 UART core
// Feeds line ticks through the input channel, predicts per-tick results with
// a cycle-free model of both line engines (typed rows give theirs as written)
// and compares each result transfer; in most phases both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_uart_8n1_transceiver_core;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [u8n1_pkg::CNT_W-1:0] cfg_wdata;

  u8n1_in_if  in_ch ();
  u8n1_out_if out_ch ();

  uart_8n1_transceiver_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // One row of the directed sequence. A row is either a bit period write or a
  // single line tick; typed rows carry a result that is obvious by inspection
  // and is checked as written instead of the predicted one.
  typedef struct packed {
    logic                       wr_period;
    logic [u8n1_pkg::CNT_W-1:0] period;
    logic                       rx;
    logic                       start;
    logic [7:0]                 data;
    logic                       typed;
    u8n1_pkg::result_t          want;
  } stim_row_t;

  localparam int N_DIRECTED = 20;

  // Rows, in order:
  //   A quiet tick straight after reset, then a send request whose start bit
  //   must appear on the same tick. A second request and a receive start bit
  //   follow while the transmitter is busy, so that request is dropped. The
  //   line then goes high again at once: a false start that still runs.
  //   A zero bit period is written mid-frame (acts as one tick and ends the
  //   current bit right away), a byte is clocked in, the stop bit is low (a
  //   framing error that is still reported), and a new send is asked for on
  //   the very tick the previous stop bit ends. Finally the longest period
  //   is written, a receive frame begins and the busy transmitter drops sends.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00}},
    '{1'b0, 16'd0,     1'b1, 1'b1, 8'hFF, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
    '{1'b0, 16'd0,     1'b0, 1'b1, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
    '{1'b1, 16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b1, 8'h3C, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b1, 8'hC3, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 16'hFFFF,  1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b1, 8'h5A, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0,     1'b1, 1'b1, 8'h81, 1'b0, '0}
  };

  // Bit periods of the random phases; zero stands for the one-tick period.
  localparam int N_PHASES       = 9;
  localparam int TICKS_PER_PHASE = 216;
  int phase_periods [N_PHASES] = '{2, 0, 5, 1, 3, 7, 4, 1, 6};

  // Predicted line engine state and the bit period as last written.
  logic [u8n1_pkg::CNT_W-1:0] bit_period;
  u8n1_pkg::phase_t           rx_ph;
  logic [u8n1_pkg::CNT_W-1:0] rx_cnt;
  logic [u8n1_pkg::IDX_W-1:0] rx_idx;
  logic [7:0]                 rx_sr;
  u8n1_pkg::phase_t           tx_ph;
  logic [u8n1_pkg::CNT_W-1:0] tx_cnt;
  logic [u8n1_pkg::IDX_W-1:0] tx_idx;
  logic [7:0]                 tx_sr;

  u8n1_pkg::result_t pending_line_results [$];
  logic              rx_wave [$];
  int                send_gap_pct;
  int                out_stall_pct;
  int                mismatches;

  // Advances both engines by one tick and returns what the line shows then.
  // The receiver moves first; the transmitter finishes its current bit before
  // it looks at a new send request, so a request on the last stop tick is
  // taken at once.
  function automatic u8n1_pkg::result_t line_tick(input logic rx, input logic start,
                                                  input logic [7:0] data);
    logic [u8n1_pkg::CNT_W-1:0] per;
    u8n1_pkg::result_t          res;
    per = (bit_period == '0) ? u8n1_pkg::CNT_W'(1) : bit_period;
    res = '0;

    case (rx_ph)
      u8n1_pkg::PH_IDLE: begin
        if (!rx) begin
          rx_ph  = u8n1_pkg::PH_START;
          rx_cnt = '0;
          rx_idx = '0;
          rx_sr  = '0;
        end
      end
      u8n1_pkg::PH_START: begin
        rx_cnt = rx_cnt + u8n1_pkg::CNT_W'(1);
        if (rx_cnt >= (per >> 1)) begin
          rx_ph  = u8n1_pkg::PH_DATA;
          rx_cnt = '0;
          rx_idx = '0;
        end
      end
      u8n1_pkg::PH_DATA: begin
        rx_cnt = rx_cnt + u8n1_pkg::CNT_W'(1);
        if (rx_cnt >= per) begin
          rx_cnt = '0;
          if (rx_idx < u8n1_pkg::BYTE_BITS_IDX) begin
            rx_sr[rx_idx[u8n1_pkg::BIT_SEL_W-1:0]] =
              rx_sr[rx_idx[u8n1_pkg::BIT_SEL_W-1:0]] | rx;
          end
          rx_idx = rx_idx + u8n1_pkg::IDX_W'(1);
          if (rx_idx >= u8n1_pkg::DATA_BITS_IDX) rx_ph = u8n1_pkg::PH_STOP;
        end
      end
      default: begin
        rx_cnt = rx_cnt + u8n1_pkg::CNT_W'(1);
        if (rx_cnt >= per) begin
          rx_cnt    = '0;
          rx_ph     = u8n1_pkg::PH_IDLE;
          res.rx_valid = 1'b1;
        end
      end
    endcase

    if (tx_ph != u8n1_pkg::PH_IDLE) begin
      tx_cnt = tx_cnt + u8n1_pkg::CNT_W'(1);
      if (tx_cnt >= per) begin
        tx_cnt = '0;
        if (tx_ph == u8n1_pkg::PH_START) begin
          tx_ph  = u8n1_pkg::PH_DATA;
          tx_idx = '0;
        end else if (tx_ph == u8n1_pkg::PH_DATA) begin
          tx_idx = tx_idx + u8n1_pkg::IDX_W'(1);
          if (tx_idx >= u8n1_pkg::DATA_BITS_IDX) tx_ph = u8n1_pkg::PH_STOP;
        end else begin
          tx_ph = u8n1_pkg::PH_IDLE;
        end
      end
    end
    if (tx_ph == u8n1_pkg::PH_IDLE && start) begin
      tx_sr  = data;
      tx_ph  = u8n1_pkg::PH_START;
      tx_cnt = '0;
      tx_idx = '0;
    end

    case (tx_ph)
      u8n1_pkg::PH_START: res.tx_line = 1'b0;
      u8n1_pkg::PH_DATA: begin
        res.tx_line = (tx_idx < u8n1_pkg::BYTE_BITS_IDX) ?
                      tx_sr[tx_idx[u8n1_pkg::BIT_SEL_W-1:0]] : 1'b0;
      end
      default:  res.tx_line = 1'b1;
    endcase
    res.tx_busy = (tx_ph != u8n1_pkg::PH_IDLE);
    res.rx_byte = rx_sr;
    return res;
  endfunction

  // Offers one tick on the input channel, holding it until the transfer, and
  // queues the result that tick must produce.
  task automatic push_tick(input logic rx, input logic start, input logic [7:0] data,
                           input logic typed, input u8n1_pkg::result_t want);
    u8n1_pkg::result_t model;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.rx_line  <= rx;
    in_ch.tx_start <= start;
    in_ch.tx_byte  <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model = line_tick(rx, start, data);
    pending_line_results.push_back(typed ? want : model);
  endtask

  // The period register may only change with no tick in flight, so the
  // channel is drained first. The line engines themselves may be mid-frame.
  task automatic write_period(input logic [u8n1_pkg::CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_line_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    bit_period  = value;
  endtask

  // Builds a receive waveform of at least n ticks at the given period. Most
  // frames are well formed with random data and random idle gaps; the rest
  // are short glitches, frames with a low stop bit and plain line noise.
  task automatic fill_rx_wave(input int period, input int n);
    int         p;
    int         kind;
    logic [7:0] data;
    p = (period == 0) ? 1 : period;
    while (rx_wave.size() < n) begin
      repeat ($urandom_range(3 * p)) rx_wave.push_back(1'b1);
      kind = $urandom_range(9);
      data = 8'($urandom);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4 * p)) rx_wave.push_back(1'($urandom_range(1)));
      end else if (kind == 1) begin
        repeat ($urandom_range(1, (p > 1) ? p / 2 : 1)) rx_wave.push_back(1'b0);
        repeat (10 * p) rx_wave.push_back(1'b1);
      end else begin
        repeat (p) rx_wave.push_back(1'b0);
        for (int b = 0; b < u8n1_pkg::DATA_BITS; b++) begin
          repeat (p) rx_wave.push_back(data[b]);
        end
        repeat (p) rx_wave.push_back(kind != 2);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result side stalls at random at the current rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Every result transfer is matched against the oldest predicted tick.
  always @(posedge clk) begin
    u8n1_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_line_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_line_results.pop_front();
        if (out_ch.tx_line !== want.tx_line) begin
          $error("tx_line: expected %0b, got %0b", want.tx_line, out_ch.tx_line);
          mismatches++;
        end
        if (out_ch.tx_busy !== want.tx_busy) begin
          $error("tx_busy: expected %0b, got %0b", want.tx_busy, out_ch.tx_busy);
          mismatches++;
        end
        if (out_ch.rx_valid !== want.rx_valid) begin
          $error("rx_valid: expected %0b, got %0b", want.rx_valid, out_ch.rx_valid);
          mismatches++;
        end
        if (out_ch.rx_byte !== want.rx_byte) begin
          $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, out_ch.rx_byte);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run with the heaviest stalls.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    // Inputs start known; the model starts from the reset state of the core.
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.rx_line  = 1'b1;
    in_ch.tx_start = 1'b0;
    in_ch.tx_byte  = '0;
    mismatches     = 0;
    send_gap_pct   = 16;
    out_stall_pct  = 55;
    bit_period     = u8n1_pkg::BIT_PERIOD_RESET;
    rx_ph  = u8n1_pkg::PH_IDLE;
    rx_cnt = '0;
    rx_idx = '0;
    rx_sr  = '0;
    tx_ph  = u8n1_pkg::PH_IDLE;
    tx_cnt = '0;
    tx_idx = '0;
    tx_sr  = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence at the reset period first, then the corner periods.
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].wr_period) begin
        write_period(directed_rows[r].period);
      end else begin
        push_tick(directed_rows[r].rx, directed_rows[r].start, directed_rows[r].data,
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases: every third one switches the idle pattern, first the
    // receiver stalls heavily, then the sender gaps heavily, then no idling.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_gap_pct  = 16;
          out_stall_pct = 55;
        end
        1: begin
          send_gap_pct  = 55;
          out_stall_pct = 16;
        end
        default: begin
          send_gap_pct  = 0;
          out_stall_pct = 0;
        end
      endcase
      write_period(u8n1_pkg::CNT_W'(phase_periods[ph]));
      fill_rx_wave(phase_periods[ph], TICKS_PER_PHASE);
      for (int t = 0; t < TICKS_PER_PHASE; t++) begin
        push_tick(rx_wave.pop_front(), ($urandom_range(3) == 0), 8'($urandom), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_line_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
